FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold on every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// ante on an edge requires cons on the same edge
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// ante on an edge requires cons on the next edge
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/swhs_pkg.sv
`timescale 1ns / 1ps
package swhs_pkg;

	localparam int DATA_BITS = 40;
	localparam int FRAME_W   = DATA_BITS;
	localparam int TICK_W    = 15;
	localparam int CNT8_W    = 8;
	localparam int BITS_W    = 6;
	localparam logic [BITS_W-1:0] DATA_BITS_C = BITS_W'(DATA_BITS);

	localparam int IN_TDATA_W  = 8;
	localparam int OUT_FIELD_W = 36;
	localparam int OUT_TDATA_W = 40;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 15;
	localparam logic [CFG_IDX_W-1:0] CFG_START_LOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd2;

	localparam logic [TICK_W-1:0] START_LOW_RST = 15'd18000;
	localparam logic [CNT8_W-1:0] RELEASE_RST   = 8'd20;
	localparam logic [CNT8_W-1:0] THRESHOLD_RST = 8'd50;

	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_START_LOW = 3'd1,
		PH_RELEASE   = 3'd2,
		PH_ACK_WAIT  = 3'd3,
		PH_ACK_LOW   = 3'd4,
		PH_ACK_HIGH  = 3'd5,
		PH_BIT_LOW   = 3'd6,
		PH_BIT_HIGH  = 3'd7
	} phase_t;

	typedef struct packed {
		logic start_request;
		logic line_level;
	} item_t;

	typedef struct packed {
		logic       checksum_ok;
		logic [7:0] temp_frac;
		logic [7:0] temp_int;
		logic [7:0] humidity_frac;
		logic [7:0] humidity_int;
		logic       done_res;
		logic       busy_res;
		logic       drive_low;
	} result_t;

endpackage

FILE: src/swhs_front.sv
`timescale 1ns / 1ps
// Input stage: registers each request and hands it to the queue.
module swhs_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [swhs_pkg::IN_TDATA_W-1:0]  in_data,
	output logic                             push_valid,
	input  logic                             push_ready,
	output swhs_pkg::item_t                  push_item
);

	logic            valid_s1;
	swhs_pkg::item_t item_s1;

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.start_request <= in_data[0];
			item_s1.line_level    <= in_data[1];
		end
	end

endmodule

FILE: src/swhs_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Short queue between the front stage and the sequencer.
module swhs_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  swhs_pkg::item_t push_item,
	output logic            pop_valid,
	input  logic            pop_ready,
	output swhs_pkg::item_t pop_item
);

	swhs_pkg::item_t                 entry_q [swhs_pkg::QUEUE_DEPTH];
	logic [swhs_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [swhs_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [swhs_pkg::QCNT_W-1:0]     count_q;
	logic                            push;
	logic                            pop;

	assign push_ready = count_q != swhs_pkg::QCNT_W'(swhs_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_item   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == swhs_pkg::QPTR_W'(swhs_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + swhs_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == swhs_pkg::QPTR_W'(swhs_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + swhs_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + swhs_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - swhs_pkg::QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	`ASSERT_ALWAYS(a_q_bound, clk, arst_n, count_q <= swhs_pkg::QCNT_W'(swhs_pkg::QUEUE_DEPTH), "queue count past depth")
	`ASSERT_NEXT(a_q_fill, clk, arst_n, push && !pop, count_q == $past(count_q) + swhs_pkg::QCNT_W'(1), "queue count missed a push")

endmodule

FILE: src/swhs_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Line sequencer: one tick per request, result into the output register.
module swhs_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [swhs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [swhs_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              q_valid,
	output logic                              q_ready,
	input  swhs_pkg::item_t                   q_item,
	output logic                              out_valid,
	input  logic                              out_ready,
	output swhs_pkg::result_t                 out_res
);

	logic [swhs_pkg::TICK_W-1:0]  start_low_q;
	logic [swhs_pkg::CNT8_W-1:0]  release_q;
	logic [swhs_pkg::CNT8_W-1:0]  thresh_q;

	swhs_pkg::phase_t             phase_q, phase_d;
	logic [swhs_pkg::TICK_W-1:0]  tick_q, tick_d, tick_inc;
	logic [swhs_pkg::CNT8_W-1:0]  high_q, high_d;
	logic [swhs_pkg::BITS_W-1:0]  bits_q, bits_d, bits_inc;
	logic [swhs_pkg::FRAME_W-1:0] shift_q, shift_d, shift_n;
	logic [swhs_pkg::FRAME_W-1:0] frame_q, frame_d;
	logic                         ck_q, ck_d;
	logic                         done;
	logic [7:0]                   byte_sum;

	logic                         out_valid_q;
	swhs_pkg::result_t            res_q, res_d;
	logic                         step;

	assign step      = q_valid && (!out_valid_q || out_ready);
	assign q_ready   = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_low_q <= swhs_pkg::START_LOW_RST;
			release_q   <= swhs_pkg::RELEASE_RST;
			thresh_q    <= swhs_pkg::THRESHOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				swhs_pkg::CFG_START_LOW: start_low_q <= cfg_data;
				swhs_pkg::CFG_RELEASE:   release_q   <= cfg_data[swhs_pkg::CNT8_W-1:0];
				swhs_pkg::CFG_THRESHOLD: thresh_q    <= cfg_data[swhs_pkg::CNT8_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= swhs_pkg::PH_IDLE;
			tick_q  <= '0;
			high_q  <= '0;
			bits_q  <= '0;
			shift_q <= '0;
			frame_q <= '0;
			ck_q    <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			high_q  <= high_d;
			bits_q  <= bits_d;
			shift_q <= shift_d;
			frame_q <= frame_d;
			ck_q    <= ck_d;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		tick_d   = tick_q;
		high_d   = high_q;
		bits_d   = bits_q;
		shift_d  = shift_q;
		frame_d  = frame_q;
		ck_d     = ck_q;
		done     = 1'b0;
		tick_inc = tick_q + swhs_pkg::TICK_W'(1);
		bits_inc = bits_q + swhs_pkg::BITS_W'(1);
		shift_n  = {shift_q[swhs_pkg::FRAME_W-2:0], (high_q > thresh_q)};
		byte_sum = shift_n[39:32] + shift_n[31:24] + shift_n[23:16] + shift_n[15:8];
		case (phase_q)
			swhs_pkg::PH_IDLE: begin
				if (q_item.start_request) begin
					phase_d = swhs_pkg::PH_START_LOW;
					tick_d  = '0;
					high_d  = '0;
					bits_d  = '0;
					shift_d = '0;
				end
			end
			swhs_pkg::PH_START_LOW: begin
				tick_d = tick_inc;
				if (tick_inc >= start_low_q) begin
					phase_d = swhs_pkg::PH_RELEASE;
					tick_d  = '0;
				end
			end
			swhs_pkg::PH_RELEASE: begin
				tick_d = tick_inc;
				if (tick_inc >= swhs_pkg::TICK_W'(release_q)) begin
					phase_d = swhs_pkg::PH_ACK_WAIT;
					tick_d  = '0;
				end
			end
			swhs_pkg::PH_ACK_WAIT: begin
				if (!q_item.line_level) phase_d = swhs_pkg::PH_ACK_LOW;
			end
			swhs_pkg::PH_ACK_LOW: begin
				if (q_item.line_level) phase_d = swhs_pkg::PH_ACK_HIGH;
			end
			swhs_pkg::PH_ACK_HIGH: begin
				if (!q_item.line_level) phase_d = swhs_pkg::PH_BIT_LOW;
			end
			swhs_pkg::PH_BIT_LOW: begin
				if (q_item.line_level) begin
					phase_d = swhs_pkg::PH_BIT_HIGH;
					high_d  = swhs_pkg::CNT8_W'(1);
				end
			end
			swhs_pkg::PH_BIT_HIGH: begin
				if (q_item.line_level) begin
					// pulse width saturates
					if (high_q != '1) high_d = high_q + swhs_pkg::CNT8_W'(1);
				end else begin
					shift_d = shift_n;
					high_d  = '0;
					if (bits_inc >= swhs_pkg::DATA_BITS_C) begin
						frame_d = shift_n;
						ck_d    = byte_sum == shift_n[7:0];
						phase_d = swhs_pkg::PH_IDLE;
						bits_d  = '0;
						done    = 1'b1;
					end else begin
						bits_d  = bits_inc;
						phase_d = swhs_pkg::PH_BIT_LOW;
					end
				end
			end
			default: phase_d = swhs_pkg::PH_IDLE;
		endcase

		res_d.drive_low     = phase_d == swhs_pkg::PH_START_LOW;
		res_d.busy_res      = phase_d != swhs_pkg::PH_IDLE;
		res_d.done_res      = done;
		res_d.humidity_int  = frame_d[39:32];
		res_d.humidity_frac = frame_d[31:24];
		res_d.temp_int      = frame_d[23:16];
		res_d.temp_frac     = frame_d[15:8];
		res_d.checksum_ok   = ck_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res_d;
		end
	end

	`ASSERT_ALWAYS(a_bits_range, clk, arst_n, bits_q < swhs_pkg::DATA_BITS_C, "bit count past frame length")
	`ASSERT_IMPLY(a_high_live, clk, arst_n, phase_q == swhs_pkg::PH_BIT_HIGH, high_q != '0, "pulse counter zero inside a pulse")
	`ASSERT_IMPLY(a_done_idle, clk, arst_n, out_valid_q && res_q.done_res, !res_q.busy_res, "done while still busy")

endmodule

FILE: src/single_wire_humidity_sensor_reader.sv
`timescale 1ns / 1ps
// Single-wire humidity/temperature sensor master.
// Each request on s_axis is one microsecond tick: the sampled data-line level
// and a start flag. Every request yields exactly one response on m_axis with
// the drive-low enable for the pad, busy, a one-tick done strobe, the four
// bytes of the last complete frame and its checksum flag.
// A start pulls the line low for start_low_ticks, releases it for
// release_ticks, waits out the sensor acknowledge, then times 40 high pulses;
// pulses longer than one_threshold decode as ones. Waits have no timeout.
// Throughput: one request per cycle while m_axis is not stalled, set by the phase sequencer.
// Each request passes through the input register, a queue entry and the
// output register before its response shows on m_axis.
// A stalled m_axis holds the output register; the input register and queue
// keep taking requests until they hold three, then s_axis_tready drops, with
// no request lost.
// Reset clears the sequencer to idle, the frame bytes and checksum flag to
// zero, and loads the register defaults (18000, 20, 50). Configuration
// writes through cfg_we/cfg_index/cfg_data take effect on the next tick.
module single_wire_humidity_sensor_reader (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [swhs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [swhs_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// start_request, line_level, zero fill
	input  logic [swhs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// drive_low, busy_res, done_res, humidity_int, humidity_frac, temp_int,
	// temp_frac, checksum_ok, zero fill
	output logic [swhs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

	logic              push_valid;
	logic              push_ready;
	swhs_pkg::item_t   push_item;
	logic              pop_valid;
	logic              pop_ready;
	swhs_pkg::item_t   pop_item;
	swhs_pkg::result_t res;

	swhs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_data    (s_axis_tdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	swhs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	swhs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (pop_valid),
		.q_ready   (pop_ready),
		.q_item    (pop_item),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tdata = {
		(swhs_pkg::OUT_TDATA_W - swhs_pkg::OUT_FIELD_W)'(0),
		res.checksum_ok,
		res.temp_frac,
		res.temp_int,
		res.humidity_frac,
		res.humidity_int,
		res.done_res,
		res.busy_res,
		res.drive_low
	};

endmodule
